FILE: src/crfe_pkg.sv
// Shared types, codes and sizes for the clipped rectangle fill engine.
// No dependencies; imported by the core and the top level.
`default_nettype none

package crfe_pkg;

  // Surface and address sizes
  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W         = $clog2(MAX_DIMENSION + 1);
  localparam int ADDR_W        = 32;
  localparam int PITCH_W       = 16;
  localparam int COORD_W       = 16;
  localparam int PIXEL_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BUSY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IDLE    = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_PITCH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SURFACE_BASE   = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0]   surface_width;
    logic [DIM_W-1:0]   surface_height;
    logic [PITCH_W-1:0] row_pitch_bytes;
    logic               swap_red_blue;
    logic [ADDR_W-1:0]  surface_base;
  } crfe_cfg_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [PIXEL_W-1:0] fill_color;
  } crfe_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                write_valid;
    logic [ADDR_W-1:0]   write_address;
    logic [PIXEL_W-1:0]  write_data;
    logic                last_write;
  } crfe_result_t;

endpackage : crfe_pkg

`default_nettype wire

FILE: src/crfe_core.sv
// Fill state and per-beat result logic of the rectangle fill engine.
// Depends on crfe_pkg; the result is combinational, the state advances on each beat.
`default_nettype none

module crfe_core
  import crfe_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fire,
  input  wire crfe_item_t   item,
  input  wire crfe_cfg_t    cfg,
  output crfe_result_t      result
);

  // Fill state
  logic              fill_active_r, fill_active_nxt;
  logic [ADDR_W-1:0] row_address_r, row_address_nxt;
  logic [DIM_W-1:0]  column_count_r, column_count_nxt;
  logic [DIM_W-1:0]  row_count_r, row_count_nxt;
  logic [DIM_W-1:0]  span_width_r, span_width_nxt;
  logic [DIM_W-1:0]  span_height_r, span_height_nxt;
  logic [PIXEL_W-1:0] pixel_value_r, pixel_value_nxt;

  // Start checks and clipping
  logic                  bad_args;
  logic [DIM_W-1:0]      avail_w, avail_h, clip_w, clip_h;
  logic [DIM_W+PITCH_W-1:0] y_offset;
  logic [ADDR_W-1:0]     start_addr;
  logic [PIXEL_W-1:0]    encoded;

  // Step logic
  logic [ADDR_W-1:0] step_addr;
  logic [DIM_W:0]    col_inc, row_inc;
  logic              last_col, last_row;

  always_comb begin
    bad_args = (cfg.surface_base == '0) ||
               (item.rect_width == '0) || (item.rect_height == '0) ||
               (cfg.surface_width > DIM_W'(MAX_DIMENSION)) ||
               (cfg.surface_height > DIM_W'(MAX_DIMENSION)) ||
               (item.rect_x >= COORD_W'(cfg.surface_width)) ||
               (item.rect_y >= COORD_W'(cfg.surface_height)) ||
               (cfg.row_pitch_bytes < PITCH_W'({cfg.surface_width, 2'b00}));

    // clip to the right and bottom edges
    avail_w = cfg.surface_width - item.rect_x[DIM_W-1:0];
    avail_h = cfg.surface_height - item.rect_y[DIM_W-1:0];
    clip_w  = (item.rect_width > COORD_W'(avail_w)) ? avail_w
                                                    : item.rect_width[DIM_W-1:0];
    clip_h  = (item.rect_height > COORD_W'(avail_h)) ? avail_h
                                                     : item.rect_height[DIM_W-1:0];

    y_offset   = (DIM_W+PITCH_W)'(item.rect_y[DIM_W-1:0]) *
                 (DIM_W+PITCH_W)'(cfg.row_pitch_bytes);
    start_addr = cfg.surface_base + ADDR_W'(y_offset) +
                 ADDR_W'({item.rect_x[DIM_W-1:0], 2'b00});

    // BGR: swap bytes 0 and 2, clear the top byte
    if (cfg.swap_red_blue) begin
      encoded = {8'h00, item.fill_color[7:0], item.fill_color[15:8],
                 item.fill_color[23:16]};
    end else begin
      encoded = item.fill_color;
    end

    step_addr = row_address_r + ADDR_W'({column_count_r, 2'b00});
    col_inc   = {1'b0, column_count_r} + (DIM_W+1)'(1);
    row_inc   = {1'b0, row_count_r} + (DIM_W+1)'(1);
    last_col  = col_inc >= {1'b0, span_width_r};
    last_row  = row_inc >= {1'b0, span_height_r};
  end

  // Build the result and the next state for this beat
  always_comb begin
    result           = '0;
    fill_active_nxt  = fill_active_r;
    row_address_nxt  = row_address_r;
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    span_width_nxt   = span_width_r;
    span_height_nxt  = span_height_r;
    pixel_value_nxt  = pixel_value_r;

    if (item.kind == KIND_START) begin
      if (fill_active_r) begin
        result.status = ST_BUSY;
      end else if (bad_args) begin
        result.status = ST_INVALID;
      end else begin
        result.status    = ST_OK;
        fill_active_nxt  = 1'b1;
        row_address_nxt  = start_addr;
        column_count_nxt = '0;
        row_count_nxt    = '0;
        span_width_nxt   = clip_w;
        span_height_nxt  = clip_h;
        pixel_value_nxt  = encoded;
      end
    end else if (!fill_active_r) begin
      result.status = ST_IDLE;
    end else begin
      result.status        = ST_OK;
      result.write_valid   = 1'b1;
      result.write_address = step_addr;
      result.write_data    = pixel_value_r;
      result.last_write    = last_col && last_row;
      if (last_col) begin
        column_count_nxt = '0;
        if (last_row) begin
          fill_active_nxt = 1'b0;
          row_count_nxt   = '0;
        end else begin
          row_count_nxt   = row_inc[DIM_W-1:0];
          // pitch is read live at each row advance
          row_address_nxt = row_address_r + ADDR_W'(cfg.row_pitch_bytes);
        end
      end else begin
        column_count_nxt = col_inc[DIM_W-1:0];
      end
    end
  end

  // Advance the state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_active_r  <= 1'b0;
      row_address_r  <= '0;
      column_count_r <= '0;
      row_count_r    <= '0;
      span_width_r   <= '0;
      span_height_r  <= '0;
      pixel_value_r  <= '0;
    end else if (fire) begin
      fill_active_r  <= fill_active_nxt;
      row_address_r  <= row_address_nxt;
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
      span_width_r   <= span_width_nxt;
      span_height_r  <= span_height_nxt;
      pixel_value_r  <= pixel_value_nxt;
    end
  end

endmodule : crfe_core

`default_nettype wire

FILE: src/clipped_rect_fill_engine_top.sv
// Clipped rectangle fill engine: top level with configuration registers,
// the fill core and a result register with a skid stage. Depends on crfe_pkg, crfe_core.
// Each result is registered in the result register, or first in the skid stage.
// Throughput: one start or step per cycle unless in_stall; one write per active step.
// in_stall rises only while the skid stage holds a result behind a stalled output.
// Reset clears the configuration registers, the fill state and both result valids.
`default_nettype none

module clipped_rect_fill_engine_top
  import crfe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_kind,
  input  wire logic [COORD_W-1:0]    in_rect_x,
  input  wire logic [COORD_W-1:0]    in_rect_y,
  input  wire logic [COORD_W-1:0]    in_rect_width,
  input  wire logic [COORD_W-1:0]    in_rect_height,
  input  wire logic [PIXEL_W-1:0]    in_fill_color,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [STATUS_W-1:0]        out_status,
  output logic                       out_write_valid,
  output logic [ADDR_W-1:0]          out_write_address,
  output logic [PIXEL_W-1:0]         out_write_data,
  output logic                       out_last_write,
  // configuration write channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  crfe_cfg_t    cfg_r;
  crfe_item_t   item;
  crfe_result_t new_result;
  crfe_result_t main_r, skid_r;
  logic         main_valid_r, skid_valid_r;
  logic         in_fire, out_fire;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SURFACE_WIDTH:  cfg_r.surface_width   <= cfg_data[DIM_W-1:0];
        REG_SURFACE_HEIGHT: cfg_r.surface_height  <= cfg_data[DIM_W-1:0];
        REG_ROW_PITCH:      cfg_r.row_pitch_bytes <= cfg_data[PITCH_W-1:0];
        REG_SWAP_RED_BLUE:  cfg_r.swap_red_blue   <= cfg_data[0];
        REG_SURFACE_BASE:   cfg_r.surface_base    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Gather the input beat
  always_comb begin
    item.kind        = in_kind;
    item.rect_x      = in_rect_x;
    item.rect_y      = in_rect_y;
    item.rect_width  = in_rect_width;
    item.rect_height = in_rect_height;
    item.fill_color  = in_fill_color;
  end

  assign in_stall = skid_valid_r;
  assign in_fire  = in_valid && !skid_valid_r;
  assign out_fire = main_valid_r && !out_stall;

  crfe_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (in_fire),
    .item   (item),
    .cfg    (cfg_r),
    .result (new_result)
  );

  // Result register and skid stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!main_valid_r || out_fire) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid_r <= 1'b0;
    end
  end

  // Move payloads; no reset needed
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        main_r <= skid_r;
      end
    end else if (in_fire) begin
      if (!main_valid_r || out_fire) begin
        main_r <= new_result;
      end else begin
        skid_r <= new_result;
      end
    end
  end

  assign out_valid         = main_valid_r;
  assign out_status        = main_r.status;
  assign out_write_valid   = main_r.write_valid;
  assign out_write_address = main_r.write_address;
  assign out_write_data    = main_r.write_data;
  assign out_last_write    = main_r.last_write;

endmodule : clipped_rect_fill_engine_top

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for clipped_rect_fill_engine_top: queued start/step beats, a
// beat-by-beat fill predictor and a field-by-field result check.
// Depends on crfe_pkg and the engine RTL.
`default_nettype none

module testbench;
  import crfe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_kind = 1'b0;
  logic [COORD_W-1:0]    in_rect_x = '0;
  logic [COORD_W-1:0]    in_rect_y = '0;
  logic [COORD_W-1:0]    in_rect_width = '0;
  logic [COORD_W-1:0]    in_rect_height = '0;
  logic [PIXEL_W-1:0]    in_fill_color = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_write_valid;
  logic [ADDR_W-1:0]     out_write_address;
  logic [PIXEL_W-1:0]    out_write_data;
  logic                  out_last_write;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  clipped_rect_fill_engine_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_rect_x(in_rect_x), .in_rect_y(in_rect_y), .in_rect_width(in_rect_width),
    .in_rect_height(in_rect_height), .in_fill_color(in_fill_color),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_write_valid(out_write_valid), .out_write_address(out_write_address),
    .out_write_data(out_write_data), .out_last_write(out_last_write),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  crfe_item_t   pending_items[$];
  crfe_result_t expected_results[$];
  int           items_queued = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           in_gap = 0;
  int           out_gap = 0;
  bit           in_beat = 1'b0;
  bit           quiet = 1'b0;

  // Predictor copy of the registers and the fill state
  logic [DIM_W-1:0]   sfc_width = '0;
  logic [DIM_W-1:0]   sfc_height = '0;
  logic [PITCH_W-1:0] sfc_pitch = '0;
  logic               sfc_bgr = 1'b0;
  logic [ADDR_W-1:0]  sfc_base = '0;
  bit                 fill_on = 1'b0;
  logic [ADDR_W-1:0]  row_addr = '0;
  logic [DIM_W-1:0]   col_pos = '0;
  logic [DIM_W-1:0]   row_pos = '0;
  logic [DIM_W-1:0]   span_cols = '0;
  logic [DIM_W-1:0]   span_rows = '0;
  logic [PIXEL_W-1:0] fill_pixel = '0;

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_SURFACE_WIDTH:  sfc_width = val[DIM_W-1:0];
      REG_SURFACE_HEIGHT: sfc_height = val[DIM_W-1:0];
      REG_ROW_PITCH:      sfc_pitch = val[PITCH_W-1:0];
      REG_SWAP_RED_BLUE:  sfc_bgr = val[0];
      REG_SURFACE_BASE:   sfc_base = val[ADDR_W-1:0];
      default: ;
    endcase
  endfunction

  // Advance the fill state by one beat and return the result it causes
  function automatic crfe_result_t fill_engine_next(crfe_item_t it);
    crfe_result_t r;
    logic [COORD_W-1:0] cols;
    logic [COORD_W-1:0] rows;
    bit last_col;
    bit last_row;
    r = '0;
    r.status = ST_OK;
    if (it.kind == KIND_START) begin
      cols = it.rect_width;
      rows = it.rect_height;
      if (fill_on) begin
        r.status = ST_BUSY;
      end else if (sfc_base == '0 || cols == '0 || rows == '0 ||
                   sfc_width > MAX_DIMENSION || sfc_height > MAX_DIMENSION ||
                   it.rect_x >= sfc_width || it.rect_y >= sfc_height ||
                   32'(sfc_pitch) < 32'(sfc_width) * 32'd4) begin
        r.status = ST_INVALID;
      end else begin
        // clip to the right and bottom surface edges
        if (cols > sfc_width - it.rect_x) cols = sfc_width - it.rect_x;
        if (rows > sfc_height - it.rect_y) rows = sfc_height - it.rect_y;
        span_cols = cols[DIM_W-1:0];
        span_rows = rows[DIM_W-1:0];
        col_pos = '0;
        row_pos = '0;
        fill_pixel = sfc_bgr ? {8'h00, it.fill_color[7:0], it.fill_color[15:8],
                                it.fill_color[23:16]} : it.fill_color;
        row_addr = sfc_base + 32'(it.rect_y) * 32'(sfc_pitch) + 32'(it.rect_x) * 32'd4;
        fill_on = 1'b1;
      end
    end else if (!fill_on) begin
      r.status = ST_IDLE;
    end else begin
      last_col = (32'(col_pos) + 1) >= 32'(span_cols);
      last_row = (32'(row_pos) + 1) >= 32'(span_rows);
      r.write_valid = 1'b1;
      r.write_address = row_addr + 32'(col_pos) * 32'd4;
      r.write_data = fill_pixel;
      r.last_write = last_col && last_row;
      if (last_col) begin
        col_pos = '0;
        if (last_row) begin
          fill_on = 1'b0;
          row_pos = '0;
        end else begin
          row_pos = row_pos + 1'b1;
          row_addr = row_addr + 32'(sfc_pitch);
        end
      end else begin
        col_pos = col_pos + 1'b1;
      end
    end
    return r;
  endfunction

  // Mostly back-to-back, sometimes a short gap, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h", $realtime, what, want, got);
      mismatches++;
    end
  endtask

  // Sample beats on all three channels
  always @(posedge clk) begin : watch_beats
    crfe_item_t   beat_item;
    crfe_result_t want;
    if (rst_n) begin
      in_beat <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, status %0d address 0x%08h",
                   $realtime, out_status, out_write_address);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(out_status), 32'(want.status));
          check_field("write_valid", 32'(out_write_valid), 32'(want.write_valid));
          check_field("write_address", out_write_address, want.write_address);
          check_field("write_data", out_write_data, want.write_data);
          check_field("last_write", 32'(out_last_write), 32'(want.last_write));
        end
      end
      if (in_valid && !in_stall) begin
        beat_item.kind = in_kind;
        beat_item.rect_x = in_rect_x;
        beat_item.rect_y = in_rect_y;
        beat_item.rect_width = in_rect_width;
        beat_item.rect_height = in_rect_height;
        beat_item.fill_color = in_fill_color;
        expected_results.push_back(fill_engine_next(beat_item));
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("testbench: done, errors");
        $finish;
      end
    end else begin
      in_beat <= 1'b0;
    end
  end

  // Feed the input channel from the pending queue; hold the payload until taken
  always @(negedge clk) begin : drive_items
    crfe_item_t nxt;
    if (rst_n && (!in_valid || in_beat)) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_kind <= nxt.kind;
        in_rect_x <= nxt.rect_x;
        in_rect_y <= nxt.rect_y;
        in_rect_width <= nxt.rect_width;
        in_rect_height <= nxt.rect_height;
        in_fill_color <= nxt.fill_color;
        in_valid <= 1'b1;
        in_gap <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Back-pressure the result channel
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_stall <= 1'b1;
      out_gap <= out_gap - 1;
    end else begin
      out_stall <= 1'b0;
      out_gap <= pick_gap();
    end
  end

  task automatic push_start(input int x, input int y, input int w, input int h,
                            input logic [31:0] color);
    crfe_item_t it;
    it.kind = KIND_START;
    it.rect_x = x[15:0];
    it.rect_y = y[15:0];
    it.rect_width = w[15:0];
    it.rect_height = h[15:0];
    it.fill_color = color;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Step beats carry don't-care fields; randomize them anyway
  task automatic push_step();
    crfe_item_t it;
    it.kind = KIND_STEP;
    it.rect_x = 16'($urandom);
    it.rect_y = 16'($urandom);
    it.rect_width = 16'($urandom);
    it.rect_height = 16'($urandom);
    it.fill_color = $urandom;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_noise_start();
    push_start($urandom_range(65535, 0), $urandom_range(65535, 0), $urandom_range(65535, 0),
               $urandom_range(65535, 0), $urandom);
  endtask

  // Wait until every queued beat is taken and every result has come back
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write all five registers back to back; call at a falling edge while idle
  task automatic set_surface(input int w, input int h, input int pitch, input bit bgr,
                             input logic [31:0] base);
    logic [CFG_IDX_W-1:0] idx [5];
    logic [31:0]          val [5];
    idx = '{REG_SURFACE_WIDTH, REG_SURFACE_HEIGHT, REG_ROW_PITCH, REG_SWAP_RED_BLUE,
            REG_SURFACE_BASE};
    val = '{32'(w), 32'(h), 32'(pitch), 32'(bgr), base};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // One well-formed fill, sometimes broken by a busy start or a trailing idle step
  task automatic push_fill(input int sw, input int sh);
    int cw, ch, x, y, w, h, n, busy_at;
    cw = $urandom_range(($urandom_range(9, 0) == 0) ? ((sw < 40) ? sw : 40) :
                        ((sw < 8) ? sw : 8), 1);
    ch = $urandom_range((sh < 8) ? sh : 8, 1);
    if ($urandom_range(1, 0)) begin
      x = sw - cw;
      w = $urandom_range(65535, cw);
    end else begin
      x = $urandom_range(sw - cw, 0);
      w = cw;
    end
    if ($urandom_range(1, 0)) begin
      y = sh - ch;
      h = $urandom_range(65535, ch);
    end else begin
      y = $urandom_range(sh - ch, 0);
      h = ch;
    end
    n = cw * ch;
    busy_at = ($urandom_range(99, 0) < 15) ? $urandom_range(n - 1, 0) : -1;
    push_start(x, y, w, h, $urandom);
    for (int i = 0; i < n; i++) begin
      if (i == busy_at) push_noise_start();
      push_step();
    end
    if ($urandom_range(9, 0) == 0) push_step();
  endtask

  // A start that must be rejected while no fill runs
  task automatic push_bad_start(input int sw, input int sh);
    case ($urandom_range(3, 0))
      0: push_start($urandom_range(65535, sw), $urandom_range(65535, 0),
                    $urandom_range(65535, 1), $urandom_range(65535, 1), $urandom);
      1: push_start($urandom_range(65535, 0), $urandom_range(65535, sh),
                    $urandom_range(65535, 1), $urandom_range(65535, 1), $urandom);
      2: push_start($urandom_range(sw - 1, 0), $urandom_range(sh - 1, 0), 0,
                    $urandom_range(65535, 0), $urandom);
      default: push_start($urandom_range(sw - 1, 0), $urandom_range(sh - 1, 0),
                          $urandom_range(65535, 0), 0, $urandom);
    endcase
  endtask

  initial begin : stimulus
    int sw, sh, pitch, target, r;
    logic [31:0] base;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: no surface, so a step is idle and a start is invalid
    push_step();
    push_start(0, 0, 1, 1, 32'h00AB_CDEF);
    drain();

    // Small surface: single pixel, clipped corner, out-of-range and zero-size rejections, busy start
    set_surface(16, 8, 64, 1'b0, 32'h1000_0000);
    push_start(0, 0, 1, 1, 32'hFFFF_FFFF);
    push_step();
    push_step();
    push_start(15, 7, 65535, 65535, 32'h0000_0000);
    push_step();
    push_start(16, 0, 1, 1, 32'h1111_1111);
    push_start(0, 8, 1, 1, 32'h2222_2222);
    push_start(0, 0, 0, 1, 32'h3333_3333);
    push_start(0, 0, 1, 0, 32'h4444_4444);
    push_start(14, 6, 2, 2, 32'h8000_0001);
    push_noise_start();
    repeat (4) push_step();
    drain();

    // BGR with a pitch one byte short, then a fill whose addresses wrap
    set_surface(16, 8, 63, 1'b1, 32'hFFFF_FFF0);
    push_start(0, 0, 1, 1, 32'h1234_5678);
    drain();
    set_surface(16, 8, 65535, 1'b1, 32'hFFFF_FFF0);
    push_start(14, 6, 2, 2, 32'h1234_5678);
    repeat (4) push_step();
    drain();

    // Largest legal surface, then oversize and empty surfaces
    set_surface(4096, 4096, 16384, 1'b0, 32'h8000_0000);
    push_start(4095, 4095, 65535, 65535, 32'hA5A5_5A5A);
    push_step();
    drain();
    set_surface(4096, 4097, 16384, 1'b0, 32'h8000_0000);
    push_start(0, 0, 1, 1, 32'h0102_0304);
    drain();
    set_surface(8191, 16, 65535, 1'b1, 32'hFFFF_FFFF);
    push_start(0, 0, 1, 1, 32'h0506_0708);
    drain();
    set_surface(0, 0, 0, 1'b0, 32'h0000_0004);
    push_start(0, 0, 1, 1, 32'h090A_0B0C);
    drain();

    // Random phases, each on a fresh surface
    for (int ph = 0; ph < 6; ph++) begin
      quiet = (ph == 2);
      sw = (ph == 4) ? 4096 : $urandom_range(64, 1);
      sh = (ph == 5) ? 4096 : $urandom_range(64, 1);
      pitch = sw * 4 + (($urandom_range(3, 0) == 0) ? $urandom_range(65535 - sw * 4, 0)
                                                     : $urandom_range(16, 0));
      base = (ph == 3) ? (32'hFFFF_FF00 | 32'($urandom_range(255, 0))) : $urandom;
      if (base == '0) base = 32'h0000_0100;
      set_surface(sw, sh, pitch, 1'($urandom_range(1, 0)), base);
      target = items_queued + 260;
      while (items_queued < target) begin
        r = $urandom_range(99, 0);
        if (r < 80) push_fill(sw, sh);
        else if (r < 92) push_bad_start(sw, sh);
        else push_step();
        // in phase 1, hold the sender mid-phase until every result is back
        if (ph == 1 && items_queued >= target - 130 && items_queued < target - 110) drain();
      end
      drain();
    end

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, expected_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
